// ===== hdl/eta_pkg.sv =====
`default_nettype none

package eta_pkg;

    // Default table depth.
    localparam int unsigned MAX_EXTENTS_DEF = 16;

    // Opcodes.
    localparam logic [3:0] OP_MARK_USED   = 4'd0;
    localparam logic [3:0] OP_MARK_UNUSED = 4'd1;
    localparam logic [3:0] OP_IS_USED     = 4'd2;
    localparam logic [3:0] OP_FIND_FIRST  = 4'd3;
    localparam logic [3:0] OP_FIRST_FREE  = 4'd4;
    localparam logic [3:0] OP_USED_TOTAL  = 4'd5;
    localparam logic [3:0] OP_FREE_TOTAL  = 4'd6;
    localparam logic [3:0] OP_LIST_USED   = 4'd7;
    localparam logic [3:0] OP_LIST_FREE   = 4'd8;

    // Result status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NO   = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_RANGE_BASE   = 1'b0;
    localparam logic CFG_RANGE_LENGTH = 1'b1;

    // One extent [ext_start, ext_end).
    typedef struct packed {
        logic [31:0] ext_start;
        logic [31:0] ext_end;
    } t_ext;

endpackage

`default_nettype wire

// ===== hdl/eta_cell.sv =====
`default_nettype none

module eta_cell
    import eta_pkg::*;
#(
    parameter int unsigned IW    = 4,
    parameter int unsigned INDEX = 0
) (
    input  wire logic          i_clk,
    input  wire logic          i_shift,
    input  wire logic          i_push,
    input  wire logic [IW-1:0] i_widx,
    input  wire t_ext          i_wdata,
    input  wire t_ext          i_next,
    output t_ext               o_data
);

    t_ext r_ext;
    logic w_sel;

    // The tail write wins over the shift, so an entry can be recycled in the
    // same cycle that the queue moves toward the head.
    assign w_sel = i_push && (i_widx == IW'(INDEX));

    always_ff @(posedge i_clk) begin
        if (w_sel) begin
            r_ext <= i_wdata;
        end else if (i_shift) begin
            r_ext <= i_next;
        end
    end

    assign o_data = r_ext;

endmodule

`default_nettype wire

// ===== hdl/extent_table_allocator.sv =====
// A query request scans every entry and then the pseudo entry at the range end
// before its final result; mark used and mark unused that change the table add
// a rebuild pass through the cell chain. A list request gives each region's result
// once the scan reaches the next region, and the last one at the end of the scan.
// One request at a time: a new request is taken only once the previous one has
// finished its walk through the cell chain; a stalled result channel holds the
// walk until the result can be given.
// Reset clears the extent count, the high-water mark and the range registers.
// Table contents are not cleared and are never read before being written.
`default_nettype none

module extent_table_allocator
    import eta_pkg::*;
#(
    parameter int unsigned MAX_EXTENTS = MAX_EXTENTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port.
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    // Request channel.
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [3:0]  i_opcode,
    input  wire logic [31:0] i_start_req,
    input  wire logic [31:0] i_length,
    // Result channel.
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_status,
    output logic [31:0]      o_region_start,
    output logic [31:0]      o_region_length,
    output logic [4:0]       o_hit_count,
    output logic [31:0]      o_high_water,
    output logic             o_last_result
);

    // Cell index width, count width, and a width that also holds count + 1.
    localparam int unsigned IW = $clog2(MAX_EXTENTS);
    localparam int unsigned CW = $clog2(MAX_EXTENTS + 1);
    localparam int unsigned KW = $clog2(MAX_EXTENTS + 2);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_BUILD = 3'b100
    } t_state;

    // The table lives in a chain of cells that works as a queue: cell 0 is the
    // head, and every pop moves each entry one cell toward the head. A scan
    // pops the head and writes it back at the tail, so after extent_count
    // steps the table is back in place. A rebuild pops the old entries and
    // pushes the new list at the tail.
    t_ext w_cell [MAX_EXTENTS];
    t_ext w_wdata;
    logic w_pop;
    logic w_push;
    logic [CW-1:0] w_widx;

    genvar g;
    generate
        for (g = 0; g < MAX_EXTENTS; g++) begin : g_cell
            t_ext w_nb;
            if (g == MAX_EXTENTS - 1) begin : g_tail
                assign w_nb = w_wdata;
            end else begin : g_mid
                assign w_nb = w_cell[g+1];
            end
            eta_cell #(
                .IW    (IW),
                .INDEX (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_shift (w_pop),
                .i_push  (w_push),
                .i_widx  (w_widx[IW-1:0]),
                .i_wdata (w_wdata),
                .i_next  (w_nb),
                .o_data  (w_cell[g])
            );
        end
    endgenerate

    // Control state.
    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_occ, n_occ;
    logic [KW-1:0] r_k, n_k;
    logic [31:0]   r_max, n_max;
    logic [31:0]   r_base, r_rlen;
    logic          r_ov, n_ov;
    logic          r_held_v, n_held_v;
    logic          r_pend_v, n_pend_v;
    logic          r_placed, n_placed;
    logic          r_flag, n_flag;
    logic          r_merged, n_merged;

    // Request payload and per-request working values.
    logic [3:0]    r_op, n_op;
    logic [31:0]   r_s, n_s;
    logic [32:0]   r_e, n_e;
    logic [31:0]   r_len, n_len;
    logic [31:0]   r_rend, n_rend;
    logic [31:0]   r_cur, n_cur;
    logic [31:0]   r_acc, n_acc;
    logic [31:0]   r_ms, n_ms;
    logic [32:0]   r_me, n_me;
    logic [CW-1:0] r_hits, n_hits;
    logic [KW-1:0] r_nn, n_nn;
    logic [31:0]   r_held_s, n_held_s;
    logic [31:0]   r_held_l, n_held_l;
    t_ext          r_pend, n_pend;

    // Output register.
    logic [1:0]    r_st, n_st;
    logic [31:0]   r_rs, n_rs;
    logic [31:0]   r_rl, n_rl;
    logic [4:0]    r_hc, n_hc;
    logic [31:0]   r_hw, n_hw;
    logic          r_last, n_last;

    // Step logic.
    logic          w_can_emit;
    logic [32:0]   w_rsum;
    logic          w_is_ent, w_is_pseudo;
    logic [31:0]   w_a, w_b;
    logic [31:0]   w_hi, w_gap_len, w_used_len, w_minl;
    logic          w_gap_v, w_cand_v, w_need_emit;
    logic [31:0]   w_cand_s, w_cand_l;
    logic          w_hit, w_lo_part, w_hi_part;
    logic          w_reject, w_full;
    t_ext          w_merged_ext;

    assign w_can_emit = !r_ov || i_out_ready;
    assign w_rsum     = {1'b0, r_base} + {1'b0, r_rlen};
    assign w_is_ent   = r_k < KW'(r_count);
    assign w_is_pseudo = r_k == KW'(r_count);

    // Past the last entry the scan sees a pseudo entry at the range end, which
    // closes the final free gap.
    assign w_a = w_is_ent ? w_cell[0].ext_start : r_rend;
    assign w_b = w_is_ent ? w_cell[0].ext_end   : 32'd0;

    assign w_hi       = (w_a < r_rend) ? w_a : r_rend;
    assign w_gap_v    = w_hi > r_cur;
    assign w_gap_len  = w_hi - r_cur;
    assign w_used_len = w_b - w_a;
    assign w_minl     = ((r_op == OP_FIRST_FREE) || (r_len == 32'd0)) ? 32'd1 : r_len;

    assign w_hit     = ({1'b0, w_a} < r_e) && (w_b > r_s);
    assign w_lo_part = w_a < r_s;
    assign w_hi_part = r_e < {1'b0, w_b};

    assign w_merged_ext = '{ext_start: r_ms, ext_end: r_me[31:0]};

    assign w_reject = (r_len == 32'd0) || (r_s < r_base) || (r_e > {1'b0, r_rend}) || r_flag;
    assign w_full   = !r_merged && (r_count == CW'(MAX_EXTENTS));

    always_comb begin
        w_cand_v = 1'b0;
        w_cand_s = r_cur;
        w_cand_l = w_gap_len;
        if (r_op == OP_LIST_USED) begin
            w_cand_v = w_is_ent && (w_used_len >= r_len);
            w_cand_s = w_a;
            w_cand_l = w_used_len;
        end else if ((r_op == OP_FIND_FIRST) || (r_op == OP_FIRST_FREE)
                     || (r_op == OP_LIST_FREE)) begin
            w_cand_v = w_gap_v && (w_gap_len >= w_minl);
        end
    end

    // A list result goes out only once the next one is found, so that the
    // last one can carry the last flag.
    assign w_need_emit = ((r_op == OP_LIST_USED) || (r_op == OP_LIST_FREE))
                         && w_cand_v && r_held_v;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_occ    = r_occ;
        n_k      = r_k;
        n_max    = r_max;
        n_held_v = r_held_v;
        n_pend_v = r_pend_v;
        n_placed = r_placed;
        n_flag   = r_flag;
        n_merged = r_merged;
        n_op     = r_op;
        n_s      = r_s;
        n_e      = r_e;
        n_len    = r_len;
        n_rend   = r_rend;
        n_cur    = r_cur;
        n_acc    = r_acc;
        n_ms     = r_ms;
        n_me     = r_me;
        n_hits   = r_hits;
        n_nn     = r_nn;
        n_held_s = r_held_s;
        n_held_l = r_held_l;
        n_pend   = r_pend;
        n_st     = r_st;
        n_rs     = r_rs;
        n_rl     = r_rl;
        n_hc     = r_hc;
        n_hw     = r_hw;
        n_last   = r_last;
        n_ov     = r_ov && !i_out_ready;
        w_pop    = 1'b0;
        w_push   = 1'b0;
        w_wdata  = w_cell[0];

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op     = i_opcode;
                    n_s      = i_start_req;
                    n_e      = {1'b0, i_start_req} + {1'b0, i_length};
                    n_len    = i_length;
                    n_rend   = w_rsum[32] ? 32'hFFFF_FFFF : w_rsum[31:0];
                    n_k      = '0;
                    n_occ    = r_count;
                    n_cur    = r_base;
                    n_acc    = '0;
                    n_flag   = 1'b0;
                    n_merged = 1'b0;
                    n_ms     = i_start_req;
                    n_me     = {1'b0, i_start_req} + {1'b0, i_length};
                    n_hits   = '0;
                    n_nn     = '0;
                    n_held_v = 1'b0;
                    n_state  = S_SCAN;
                end
            end

            S_SCAN: begin
                if (w_is_ent || w_is_pseudo) begin
                    if (!w_need_emit || w_can_emit) begin
                        n_k = r_k + KW'(1);
                        if (w_is_ent) begin
                            w_pop  = 1'b1;
                            w_push = 1'b1;
                        end
                        if (w_b > r_cur) begin
                            n_cur = w_b;
                        end
                        if (w_need_emit) begin
                            n_ov   = 1'b1;
                            n_st   = ST_OK;
                            n_rs   = r_held_s;
                            n_rl   = r_held_l;
                            n_hc   = '0;
                            n_hw   = r_max;
                            n_last = 1'b0;
                        end
                        priority case (r_op)
                            OP_MARK_USED: begin
                                if (w_is_ent) begin
                                    if ((w_a <= r_s) && (r_e <= {1'b0, w_b})) begin
                                        n_flag = 1'b1;
                                    end
                                    if (({1'b0, w_a} <= r_e) && (w_b >= r_s)) begin
                                        n_merged = 1'b1;
                                        if (w_a < r_ms) begin
                                            n_ms = w_a;
                                        end
                                        if ({1'b0, w_b} > r_me) begin
                                            n_me = {1'b0, w_b};
                                        end
                                    end
                                end
                            end
                            OP_MARK_UNUSED: begin
                                if (w_is_ent) begin
                                    if (w_hit) begin
                                        n_hits = r_hits + CW'(1);
                                        n_nn   = r_nn + KW'(w_lo_part) + KW'(w_hi_part);
                                    end else begin
                                        n_nn   = r_nn + KW'(1);
                                    end
                                end
                            end
                            OP_IS_USED: begin
                                if (w_is_ent && (w_a <= r_s) && (r_e <= {1'b0, w_b})) begin
                                    n_flag = 1'b1;
                                end
                            end
                            OP_FIND_FIRST, OP_FIRST_FREE: begin
                                if (w_cand_v && !r_held_v) begin
                                    n_held_v = 1'b1;
                                    n_held_s = w_cand_s;
                                    n_held_l = w_cand_l;
                                end
                            end
                            OP_USED_TOTAL: begin
                                if (w_is_ent) begin
                                    n_acc = r_acc + w_used_len;
                                end
                            end
                            OP_FREE_TOTAL: begin
                                if (w_gap_v) begin
                                    n_acc = r_acc + w_gap_len;
                                end
                            end
                            OP_LIST_USED, OP_LIST_FREE: begin
                                if (w_cand_v) begin
                                    n_held_v = 1'b1;
                                    n_held_s = w_cand_s;
                                    n_held_l = w_cand_l;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end else begin
                    // Final step: either start the rebuild or give the result.
                    if ((r_op == OP_MARK_USED) && !w_reject && !w_full) begin
                        n_state  = S_BUILD;
                        n_k      = '0;
                        n_occ    = r_count;
                        n_pend_v = 1'b0;
                        n_placed = 1'b0;
                    end else if ((r_op == OP_MARK_UNUSED) && (r_nn <= KW'(MAX_EXTENTS))
                                 && (r_hits != '0)) begin
                        n_state  = S_BUILD;
                        n_k      = '0;
                        n_occ    = r_count;
                        n_pend_v = 1'b0;
                        n_placed = 1'b0;
                    end else if (w_can_emit) begin
                        n_ov    = 1'b1;
                        n_st    = ST_NO;
                        n_rs    = '0;
                        n_rl    = '0;
                        n_hc    = '0;
                        n_hw    = r_max;
                        n_last  = 1'b1;
                        n_state = S_IDLE;
                        priority case (r_op)
                            OP_MARK_USED: begin
                                n_st = w_reject ? ST_NO : ST_FULL;
                            end
                            OP_MARK_UNUSED: begin
                                n_st = (r_nn > KW'(MAX_EXTENTS)) ? ST_FULL : ST_NO;
                            end
                            OP_IS_USED: begin
                                n_st = r_flag ? ST_OK : ST_NO;
                            end
                            OP_FIND_FIRST, OP_FIRST_FREE, OP_LIST_USED, OP_LIST_FREE: begin
                                if (r_held_v) begin
                                    n_st = ST_OK;
                                    n_rs = r_held_s;
                                    n_rl = r_held_l;
                                end
                            end
                            OP_USED_TOTAL, OP_FREE_TOTAL: begin
                                n_st = ST_OK;
                                n_rl = r_acc;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end

            S_BUILD: begin
                // A split or the newly placed extent can yield two entries
                // from one; the second waits in the pending register.
                if (r_pend_v) begin
                    w_push   = 1'b1;
                    w_wdata  = r_pend;
                    n_pend_v = 1'b0;
                end else if (w_is_ent) begin
                    w_pop = 1'b1;
                    n_k   = r_k + KW'(1);
                    if (r_op == OP_MARK_USED) begin
                        if (w_b < r_s) begin
                            w_push = 1'b1;
                        end else if ({1'b0, w_a} > r_e) begin
                            w_push = 1'b1;
                            if (!r_placed) begin
                                w_wdata  = w_merged_ext;
                                n_placed = 1'b1;
                                n_pend_v = 1'b1;
                                n_pend   = w_cell[0];
                            end
                        end
                    end else begin
                        if (!w_hit) begin
                            w_push = 1'b1;
                        end else if (w_lo_part) begin
                            w_push  = 1'b1;
                            w_wdata = '{ext_start: w_a, ext_end: r_s};
                            if (w_hi_part) begin
                                n_pend_v = 1'b1;
                                n_pend   = '{ext_start: r_e[31:0], ext_end: w_b};
                            end
                        end else if (w_hi_part) begin
                            w_push  = 1'b1;
                            w_wdata = '{ext_start: r_e[31:0], ext_end: w_b};
                        end
                    end
                end else if ((r_op == OP_MARK_USED) && !r_placed) begin
                    w_push   = 1'b1;
                    w_wdata  = w_merged_ext;
                    n_placed = 1'b1;
                end else if (w_can_emit) begin
                    n_count = r_occ;
                    if ((r_op == OP_MARK_USED) && (r_e > {1'b0, r_max})) begin
                        n_max = r_e[31:0];
                    end
                    n_ov    = 1'b1;
                    n_st    = ST_OK;
                    n_rs    = '0;
                    n_rl    = '0;
                    n_hc    = (r_op == OP_MARK_UNUSED) ? 5'(r_hits) : 5'd0;
                    n_hw    = ((r_op == OP_MARK_USED) && (r_e > {1'b0, r_max}))
                              ? r_e[31:0] : r_max;
                    n_last  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_occ = n_occ - CW'(w_pop) + CW'(w_push);
    end

    // The tail slot sits behind the entries that remain after this pop.
    assign w_widx = r_occ - CW'(w_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_occ    <= '0;
            r_k      <= '0;
            r_max    <= '0;
            r_base   <= '0;
            r_rlen   <= '0;
            r_ov     <= 1'b0;
            r_held_v <= 1'b0;
            r_pend_v <= 1'b0;
            r_placed <= 1'b0;
            r_flag   <= 1'b0;
            r_merged <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_occ    <= n_occ;
            r_k      <= n_k;
            r_max    <= n_max;
            r_ov     <= n_ov;
            r_held_v <= n_held_v;
            r_pend_v <= n_pend_v;
            r_placed <= n_placed;
            r_flag   <= n_flag;
            r_merged <= n_merged;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_RANGE_BASE:   r_base <= i_cfg_data;
                    CFG_RANGE_LENGTH: r_rlen <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_s      <= n_s;
        r_e      <= n_e;
        r_len    <= n_len;
        r_rend   <= n_rend;
        r_cur    <= n_cur;
        r_acc    <= n_acc;
        r_ms     <= n_ms;
        r_me     <= n_me;
        r_hits   <= n_hits;
        r_nn     <= n_nn;
        r_held_s <= n_held_s;
        r_held_l <= n_held_l;
        r_pend   <= n_pend;
        r_st     <= n_st;
        r_rs     <= n_rs;
        r_rl     <= n_rl;
        r_hc     <= n_hc;
        r_hw     <= n_hw;
        r_last   <= n_last;
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_ov;
    assign o_status        = r_st;
    assign o_region_start  = r_rs;
    assign o_region_length = r_rl;
    assign o_hit_count     = r_hc;
    assign o_high_water    = r_hw;
    assign o_last_result   = r_last;

    // The table never holds more extents than it has cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_EXTENTS))
        else $error("extent count above table depth");

    // A rebuild never overflows the chain.
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BUILD) |-> (r_occ <= CW'(MAX_EXTENTS)))
        else $error("rebuild queue overflow");

    // The high-water mark never falls.
    a_hw_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 (r_max >= $past(r_max)))
        else $error("high-water mark decreased");

    // The table only changes size at the end of a rebuild.
    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_BUILD) |=> (r_count == $past(r_count)))
        else $error("extent count changed outside a rebuild");

endmodule

`default_nettype wire
